// ===== src/quaternion_attitude_integrator_assert.svh =====
// Assertion macros for the quaternion attitude integrator.
// No dependencies; included inside module bodies.
`ifndef QUATERNION_ATTITUDE_INTEGRATOR_ASSERT_SVH
`define QUATERNION_ATTITUDE_INTEGRATOR_ASSERT_SVH
// implication checked on every clock edge outside reset
`define QAI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// implication checked also during reset
`define QAI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/qai_pkg.sv =====
// Shared types and constants for the quaternion attitude integrator.
// No dependencies.
package qai_pkg;
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
   localparam int SUM_W = 52;   // width of component plus increment
   localparam int MAG_W = 64;

   // request to the shared divider / square-root unit
   typedef struct packed {
      logic        start;
      logic        is_sqrt;
      logic [63:0] num;
      logic [31:0] den;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } alu_rsp_type;
endpackage

// ===== src/qai_alu.sv =====
// Shared radix-2 unit: unsigned 64/32 division or 64-bit integer square root.
// One result bit per cycle. Depends on qai_pkg.
module qai_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  qai_pkg::alu_req_type req,
   output qai_pkg::alu_rsp_type rsp
);
   import qai_pkg::*;

   logic        busy_ff, busy_in;
   logic        sqrt_ff, sqrt_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] quo_ff, quo_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic [33:0] shrem;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      shrem   = '0;
      trial   = '0;
      if (req.start) begin
         busy_in = 1'b1;
         sqrt_in = req.is_sqrt;
         cnt_in  = 6'd32;
         den_in  = req.den;
         quo_in  = '0;
         if (req.is_sqrt) begin
            num_in = req.num;
            rem_in = '0;
         end else begin
            // high part is below den, so the quotient fits 32 bits
            rem_in = {2'b00, req.num[63:32]};
            num_in = {req.num[31:0], 32'd0};
         end
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            shrem = {rem_ff[31:0], num_ff[63:62]};
            trial = shrem - {quo_ff, 2'b01};
            num_in = {num_ff[61:0], 2'b00};
            if (!trial[33]) begin
               rem_in = trial;
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = shrem;
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end else begin
            shrem = {rem_ff[32:0], num_ff[63]};
            trial = shrem - {2'b00, den_ff};
            num_in = {num_ff[62:0], 1'b0};
            if (!trial[33]) begin
               rem_in = trial;
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = shrem;
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sqrt_ff <= sqrt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = quo_ff;

   `include "quaternion_attitude_integrator_assert.svh"
   `QAI_ASSERT(a_done_after_busy, clock, reset, rsp.done |-> $past(busy_ff), "done without work")
   `QAI_ASSERT(a_cnt_zero_idle, clock, reset, !busy_ff |-> cnt_ff == 6'd0 || $past(busy_ff) == 1'b0, "idle count")
   `QAI_ASSERT(a_start_busy, clock, reset, req.start |=> busy_ff, "start not taken")
endmodule

// ===== src/qai_core.sv =====
// Sequencer: derivative, Euler step, block scaling and normalisation.
// Depends on qai_pkg and qai_alu.
module qai_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [15:0]  rate_x,
   input  logic signed [15:0]  rate_y,
   input  logic signed [15:0]  rate_z,
   input  logic [15:0]         step_time,
   output logic                done,
   output logic signed [31:0]  q_w,
   output logic signed [31:0]  q_x,
   output logic signed [31:0]  q_y,
   output logic signed [31:0]  q_z,
   output logic                err
);
   import qai_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MAC  = 4'd1;
   localparam logic [3:0] S_INC  = 4'd2;
   localparam logic [3:0] S_MAX  = 4'd3;
   localparam logic [3:0] S_SCL  = 4'd4;
   localparam logic [3:0] S_SQ   = 4'd5;
   localparam logic [3:0] S_RT   = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_DIVW = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0]  st_ff, st_in;
   logic [3:0]  k_ff, k_in;       // product index within the twelve
   logic [1:0]  c_ff, c_in;       // component index
   logic signed [31:0] q_ff [4];
   logic signed [31:0] q_in [4];
   logic signed [SUM_W-1:0] s_ff [4];
   logic signed [SUM_W-1:0] s_in [4];
   logic [MAG_W-1:0] m_ff [4];
   logic [MAG_W-1:0] m_in [4];
   logic        neg_ff [4];
   logic        neg_in [4];
   logic [MAG_W-1:0] mx_ff, mx_in;
   logic [MAG_W-1:0] sq_ff, sq_in;
   logic [31:0] nrm_ff, nrm_in;
   logic        err_ff, err_in;
   logic        done_ff, done_in;
   logic signed [47:0] prod;
   logic signed [15:0] mr;
   logic signed [31:0] mq;
   logic        msub;
   logic [1:0]  mc;
   logic [50:0] smag;
   logic [66:0] inc;
   logic [50:0] iq;
   logic signed [SUM_W-1:0] incs;
   logic [63:0] sqr;
   alu_req_type areq;
   alu_rsp_type arsp;

   qai_alu u_alu (.clock(clock), .reset(reset), .req(areq), .rsp(arsp));

   // product table: component, rate, quaternion term, sign
   always_comb begin
      mc = 2'd0; mr = rate_x; mq = q_ff[1]; msub = 1'b1;
      case (k_ff)
         4'd0:  begin mc = 2'd0; mr = rate_x; mq = q_ff[1]; msub = 1'b1; end
         4'd1:  begin mc = 2'd0; mr = rate_y; mq = q_ff[2]; msub = 1'b1; end
         4'd2:  begin mc = 2'd0; mr = rate_z; mq = q_ff[3]; msub = 1'b1; end
         4'd3:  begin mc = 2'd1; mr = rate_x; mq = q_ff[0]; msub = 1'b0; end
         4'd4:  begin mc = 2'd1; mr = rate_y; mq = q_ff[3]; msub = 1'b0; end
         4'd5:  begin mc = 2'd1; mr = rate_z; mq = q_ff[2]; msub = 1'b1; end
         4'd6:  begin mc = 2'd2; mr = rate_x; mq = q_ff[3]; msub = 1'b1; end
         4'd7:  begin mc = 2'd2; mr = rate_y; mq = q_ff[0]; msub = 1'b0; end
         4'd8:  begin mc = 2'd2; mr = rate_z; mq = q_ff[1]; msub = 1'b0; end
         4'd9:  begin mc = 2'd3; mr = rate_x; mq = q_ff[2]; msub = 1'b0; end
         4'd10: begin mc = 2'd3; mr = rate_y; mq = q_ff[1]; msub = 1'b1; end
         4'd11: begin mc = 2'd3; mr = rate_z; mq = q_ff[0]; msub = 1'b0; end
         default: begin mc = 2'd0; mr = rate_x; mq = q_ff[1]; msub = 1'b1; end
      endcase
      prod = mr * mq;
   end

   // increment: |S|*dt/2^29 rounded half away from zero
   always_comb begin
      smag = s_ff[c_ff][SUM_W-1] ? 51'(-s_ff[c_ff]) : 51'(s_ff[c_ff]);
      inc  = 67'(smag) * 67'(step_time) + (67'd1 << 28);
      iq   = inc[66:29] > 38'h3FFFFFFFFF ? '1 : 51'(inc[66:29]);
      incs = s_ff[c_ff][SUM_W-1] ? -SUM_W'(signed'(iq)) : SUM_W'(signed'(iq));
      sqr  = m_ff[c_ff][31:0] * m_ff[c_ff][31:0];
   end

   always_comb begin
      st_in = st_ff; k_in = k_ff; c_in = c_ff;
      q_in = q_ff; s_in = s_ff; m_in = m_ff; neg_in = neg_ff;
      mx_in = mx_ff; sq_in = sq_ff; nrm_in = nrm_ff; err_in = err_ff;
      done_in = 1'b0;
      areq = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               st_in = S_MAC; k_in = '0;
               for (int i = 0; i < 4; i++) s_in[i] = '0;
            end
         end
         S_MAC: begin
            s_in[mc] = msub ? s_ff[mc] - SUM_W'(prod) : s_ff[mc] + SUM_W'(prod);
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd11) begin
               st_in = S_INC; c_in = '0;
            end
         end
         S_INC: begin
            s_in[c_ff] = SUM_W'(q_ff[c_ff]) + incs;
            c_in = c_ff + 2'd1;
            if (c_ff == 2'd3) begin
               st_in = S_MAX; mx_in = '0;
            end
         end
         S_MAX: begin
            neg_in[c_ff] = s_ff[c_ff][SUM_W-1];
            m_in[c_ff] = s_ff[c_ff][SUM_W-1] ? MAG_W'(-s_ff[c_ff]) : MAG_W'(s_ff[c_ff]);
            if (m_in[c_ff] > mx_ff) mx_in = m_in[c_ff];
            c_in = c_ff + 2'd1;
            if (c_ff == 2'd3) begin
               if (mx_in == '0) begin
                  err_in = 1'b1;
                  q_in[0] = ONE_Q30; q_in[1] = '0; q_in[2] = '0; q_in[3] = '0;
                  st_in = S_DONE;
               end else begin
                  err_in = 1'b0;
                  st_in = S_SCL;
               end
            end
         end
         // one bit of block shift per cycle
         S_SCL: begin
            if (mx_ff >= (MAG_W'(1) << 31)) begin
               mx_in = mx_ff >> 1;
               for (int i = 0; i < 4; i++) m_in[i] = m_ff[i] >> 1;
            end else if (mx_ff < (MAG_W'(1) << 30)) begin
               mx_in = mx_ff << 1;
               for (int i = 0; i < 4; i++) m_in[i] = m_ff[i] << 1;
            end else begin
               st_in = S_SQ; c_in = '0; sq_in = '0;
            end
         end
         S_SQ: begin
            sq_in = sq_ff + sqr;
            c_in = c_ff + 2'd1;
            if (c_ff == 2'd3) begin
               st_in = S_RT;
               areq.start = 1'b1; areq.is_sqrt = 1'b1; areq.num = sq_in;
            end
         end
         S_RT: begin
            if (arsp.done) begin
               nrm_in = arsp.result;
               st_in = S_DIV; c_in = '0;
            end
         end
         S_DIV: begin
            areq.start = 1'b1; areq.is_sqrt = 1'b0; areq.den = nrm_ff;
            areq.num = {2'b00, m_ff[c_ff][31:0], 30'd0} + 64'(nrm_ff[31:1]);
            st_in = S_DIVW;
         end
         S_DIVW: begin
            if (arsp.done) begin
               q_in[c_ff] = neg_ff[c_ff] ? -signed'(arsp.result) : signed'(arsp.result);
               c_in = c_ff + 2'd1;
               st_in = (c_ff == 2'd3) ? S_DONE : S_DIV;
            end
         end
         S_DONE: begin
            done_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         k_ff    <= '0;
         c_ff    <= '0;
         done_ff <= 1'b0;
         q_ff[0] <= ONE_Q30;
         q_ff[1] <= '0;
         q_ff[2] <= '0;
         q_ff[3] <= '0;
      end else begin
         st_ff   <= st_in;
         k_ff    <= k_in;
         c_ff    <= c_in;
         done_ff <= done_in;
         q_ff    <= q_in;
      end
      s_ff   <= s_in;
      m_ff   <= m_in;
      neg_ff <= neg_in;
      mx_ff  <= mx_in;
      sq_ff  <= sq_in;
      nrm_ff <= nrm_in;
      err_ff <= err_in;
   end

   assign done = done_ff;
   assign q_w  = q_ff[0];
   assign q_x  = q_ff[1];
   assign q_y  = q_ff[2];
   assign q_z  = q_ff[3];
   assign err  = err_ff;

   `include "quaternion_attitude_integrator_assert.svh"
   `QAI_ASSERT(a_start_idle, clock, reset, start |-> st_ff == S_IDLE, "start while busy")
   `QAI_ASSERT(a_done_idle, clock, reset, done |-> st_ff == S_IDLE, "done not back to idle")
   `QAI_ASSERT(a_err_identity, clock, reset, (done && err) |-> q_w == ONE_Q30 && q_x == 0, "error without identity")
endmodule

// ===== src/quaternion_attitude_integrator.sv =====
// Top level of the quaternion attitude integrator.
// Depends on qai_pkg, qai_core (and qai_alu beneath it).
//
// Usage:
//   Request words (req_rate_x/y/z) arrive on req_valid/req_ready. One word
//   is worked at a time; req_ready is low from acceptance until the result
//   has been taken from the output register.
//   Result words leave on rsp_valid/rsp_ready from an output register.
//   The work between acceptance and rsp_valid is twelve
//   multiply-accumulate steps, four increment steps, four magnitude steps,
//   0 to 30 block-shift steps, a square root and four divisions, all on
//   one shared radix-2 unit. A zero magnitude skips the normalisation.
//   req_ready rises the cycle after the result word is taken.
//   A stalled receiver holds the result register; a new word is not taken
//   until the held result has gone.
//   Reset sets the orientation to identity and step_time to 66.
//   csr_we writes step_time; write it only while idle.
//   A zero magnitude returns identity with rsp_norm_error set.
module quaternion_attitude_integrator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_rate_x,
   input  logic signed [15:0] req_rate_y,
   input  logic signed [15:0] req_rate_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_att_w,
   output logic signed [31:0] rsp_att_x,
   output logic signed [31:0] rsp_att_y,
   output logic signed [31:0] rsp_att_z,
   output logic               rsp_norm_error,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata
);
   import qai_pkg::*;

   logic        busy_ff, busy_in;
   logic        vld_ff, vld_in;
   logic [15:0] step_ff;
   logic signed [15:0] rx_ff, ry_ff, rz_ff;
   logic        start_ff;
   logic        done;
   logic signed [31:0] qw, qx, qy, qz;
   logic        err;
   logic signed [31:0] ow_ff, ox_ff, oy_ff, oz_ff;
   logic        oe_ff;
   logic        acc;

   assign acc       = req_valid && req_ready;
   assign req_ready = !busy_ff && !vld_ff;

   qai_core u_core (
      .clock(clock), .reset(reset), .start(start_ff),
      .rate_x(rx_ff), .rate_y(ry_ff), .rate_z(rz_ff), .step_time(step_ff),
      .done(done), .q_w(qw), .q_x(qx), .q_y(qy), .q_z(qz), .err(err)
   );

   // handshake control
   always_comb begin
      busy_in = busy_ff;
      vld_in  = vld_ff;
      if (acc) busy_in = 1'b1;
      if (done) begin
         busy_in = 1'b0;
         vld_in  = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         vld_ff   <= 1'b0;
         start_ff <= 1'b0;
         step_ff  <= 16'd66;
      end else begin
         busy_ff  <= busy_in;
         vld_ff   <= vld_in;
         start_ff <= acc;
         if (csr_we) step_ff <= csr_wdata;
      end
      if (acc) begin
         rx_ff <= req_rate_x;
         ry_ff <= req_rate_y;
         rz_ff <= req_rate_z;
      end
      if (done) begin
         ow_ff <= qw; ox_ff <= qx; oy_ff <= qy; oz_ff <= qz; oe_ff <= err;
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_att_w      = ow_ff;
   assign rsp_att_x      = ox_ff;
   assign rsp_att_y      = oy_ff;
   assign rsp_att_z      = oz_ff;
   assign rsp_norm_error = oe_ff;

   `include "quaternion_attitude_integrator_assert.svh"
   `QAI_ASSERT(a_done_busy, clock, reset, done |-> busy_ff && !vld_ff, "result with no word")
   `QAI_ASSERT(a_no_accept_busy, clock, reset, busy_ff |-> !req_ready, "accept while busy")
   `QAI_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "valid after reset")
endmodule
